FILE: hdl/brs_pkg.sv
// Shared types and constants for the bucketed running statistics core.
// No dependencies; imported by bucketed_running_stats_core and brs_checker.
package brs_pkg;

  localparam int unsigned Buckets = 1024;
  localparam int unsigned IdxW    = (Buckets > 1) ? $clog2(Buckets) : 1;
  localparam int unsigned DivSteps = 64;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // One bucket entry as it sits in the statistics memory.
  typedef struct packed {
    logic [31:0] count;
    logic [47:0] mean;
    logic [63:0] variance;
    logic [31:0] min;
    logic [31:0] max;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_V0,
    ST_V1,
    ST_M0,
    ST_M1,
    ST_D0,
    ST_D1,
    ST_D2,
    ST_DIV,
    ST_WRITE
  } state_e;

  // Which quotient the shared divider is producing.
  typedef enum logic [1:0] {
    PH_VAR,
    PH_MEAN,
    PH_SQ
  } phase_e;

endpackage

FILE: hdl/brs_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module brs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hdl/bucketed_running_stats_core.sv
// Bucketed running statistics core: per-bucket count, mean, variance, min, max.
// Depends on brs_pkg and brs_ram (statistics memory).
//
// Each accepted item (bucket 1..Buckets, latency sample) updates that bucket and
// returns its new statistics as one item. One item is in work at a time. An
// out-of-range bucket (result all zero) skips the memory read and a bucket's first
// sample skips the arithmetic; for a later sample one 32x32 multiply-accumulate unit
// builds three dividends and one radix-2 divider produces the scaled variance, the
// mean and the squared-deviation term in turn. After reset a clearing pass zeroes
// the memory before the first item is accepted. A finished result sits in an output
// register, so the next item is taken while it waits; only a second finished result
// waits for it.
module bucketed_running_stats_core
  import brs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [10:0] size_bucket_i,
  input  logic [31:0] latency_sample_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] sample_count_o,
  output logic [47:0] running_mean_o,
  output logic [63:0] running_variance_o,
  output logic [31:0] least_latency_o,
  output logic [31:0] greatest_latency_o
);

  state_e state_q, state_d;
  phase_e phase_q;

  logic [IdxW-1:0]    clr_idx_q;
  logic [IdxW-1:0]    idx_q;
  logic [31:0]        x_q;
  logic [31:0]        n_q;
  logic               oor_q;
  logic               first_q;
  entry_t             entry_q;
  logic [95:0]        acc_q;
  logic [31:0]        rem_q;
  logic [63:0]        quo_q;
  logic [31:0]        div_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic [63:0]        t1_q;
  logic [47:0]        mean_q;
  logic               out_valid_q;
  entry_t             out_q;

  logic               accept;
  logic               in_range;
  logic [31:0]        bucket_off;
  logic [IdxW-1:0]    in_idx;
  entry_t             rd_entry;
  logic               mem_we;
  logic [IdxW-1:0]    mem_waddr;
  entry_t             mem_wdata;
  logic [31:0]        n_new;
  logic [47:0]        xs;
  logic [47:0]        dev;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;
  logic [95:0]        acc_next;
  logic [32:0]        div_sh;
  logic               div_ge;
  logic [31:0]        div_rem;
  logic [64:0]        var_sum;
  logic [63:0]        var_new;
  entry_t             upd;
  logic               out_free;

  assign in_range   = (size_bucket_i != 11'd0) && (32'(size_bucket_i) <= 32'(Buckets));
  assign bucket_off = 32'(size_bucket_i) - 32'd1;
  assign in_idx     = bucket_off[IdxW-1:0];
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  brs_ram #(
    .Width(EntryW),
    .Depth(Buckets)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(in_idx),
    .rdata_o(rd_entry)
  );

  assign n_new = (rd_entry.count == 32'hFFFF_FFFF) ? rd_entry.count : rd_entry.count + 32'd1;
  assign xs    = {x_q, 16'h0000};
  assign dev   = (xs >= entry_q.mean) ? (xs - entry_q.mean) : (entry_q.mean - xs);

  // Shared multiplier; operands chosen by the sequencer step.
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state_q)
      ST_V0:   begin mul_a = entry_q.variance[31:0];  mul_b = n_q - 32'd2; end
      ST_V1:   begin mul_a = entry_q.variance[63:32]; mul_b = n_q - 32'd2; end
      ST_M0:   begin mul_a = entry_q.mean[31:0];      mul_b = n_q - 32'd1; end
      ST_M1:   begin mul_a = {16'h0, entry_q.mean[47:32]}; mul_b = n_q - 32'd1; end
      ST_D0:   begin mul_a = dev[31:0];               mul_b = dev[31:0]; end
      ST_D1:   begin mul_a = {16'h0, dev[47:32]};     mul_b = dev[31:0]; end
      ST_D2:   begin mul_a = {16'h0, dev[47:32]};     mul_b = {16'h0, dev[47:32]}; end
      default: begin mul_a = 32'd0;                   mul_b = 32'd0; end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    unique case (state_q)
      ST_V0:   acc_next = {32'h0, prod};
      ST_M0:   acc_next = {32'h0, prod} + {48'h0, xs};
      ST_D0:   acc_next = {64'h0, prod[63:32]};
      ST_D1:   acc_next = acc_q + {31'h0, prod, 1'b0};
      ST_V1, ST_M1, ST_D2: acc_next = acc_q + {prod, 32'h0};
      default: acc_next = acc_q;
    endcase
  end

  // Restoring divider, one quotient bit per cycle.
  assign div_sh  = {rem_q, quo_q[63]};
  assign div_ge  = (div_sh >= {1'b0, div_q});
  assign div_rem = div_ge ? 32'(div_sh - {1'b0, div_q}) : div_sh[31:0];

  assign var_sum = {1'b0, t1_q} + {1'b0, quo_q};
  assign var_new = var_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : var_sum[63:0];

  always_comb begin
    upd = entry_q;
    upd.count = n_q;
    if (first_q) begin
      upd.mean     = xs;
      upd.variance = 64'd0;
      upd.min      = x_q;
      upd.max      = x_q;
    end else begin
      upd.mean     = mean_q;
      upd.variance = var_new;
      upd.min      = (entry_q.min > x_q) ? x_q : entry_q.min;
      upd.max      = (entry_q.max < x_q) ? x_q : entry_q.max;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = upd;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_q;
      mem_wdata = '0;
    end else if (state_q == ST_WRITE && out_free && !oor_q) begin
      mem_we = 1'b1;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_idx_q == IdxW'(Buckets - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (accept) state_d = in_range ? ST_READ : ST_WRITE;
      ST_READ:  state_d = (n_new > 32'd1) ? ST_V0 : ST_WRITE;
      ST_V0:    state_d = ST_V1;
      ST_V1:    state_d = ST_DIV;
      ST_M0:    state_d = ST_M1;
      ST_M1:    state_d = ST_DIV;
      ST_D0:    state_d = ST_D1;
      ST_D1:    state_d = ST_D2;
      ST_D2:    state_d = ST_DIV;
      ST_DIV: begin
        if (div_cnt_q == DivCntW'(DivSteps - 1)) begin
          unique case (phase_q)
            PH_VAR:  state_d = ST_M0;
            PH_MEAN: state_d = ST_D0;
            PH_SQ:   state_d = ST_WRITE;
            default: state_d = ST_WRITE;
          endcase
        end
      end
      ST_WRITE: if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_idx_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_idx_q <= clr_idx_q + IdxW'(1);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_VAR;
      div_cnt_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            idx_q <= in_idx;
            x_q   <= latency_sample_i;
            oor_q <= !in_range;
          end
        end
        ST_READ: begin
          entry_q <= rd_entry;
          n_q     <= n_new;
          first_q <= (n_new <= 32'd1);
        end
        ST_V0, ST_M0, ST_D0, ST_D1: acc_q <= acc_next;
        ST_V1, ST_M1, ST_D2: begin
          rem_q     <= acc_next[95:64];
          quo_q     <= acc_next[63:0];
          div_cnt_q <= '0;
          div_q     <= (state_q == ST_V1) ? n_q - 32'd1 : n_q;
          phase_q   <= (state_q == ST_V1) ? PH_VAR : (state_q == ST_M1) ? PH_MEAN : PH_SQ;
        end
        ST_DIV: begin
          rem_q     <= div_rem;
          quo_q     <= {quo_q[62:0], div_ge};
          div_cnt_q <= div_cnt_q + DivCntW'(1);
          if (div_cnt_q == DivCntW'(DivSteps - 1)) begin
            if (phase_q == PH_VAR) t1_q <= {quo_q[62:0], div_ge};
            // mean quotient always fits in 48 bits
            if (phase_q == PH_MEAN) mean_q <= {quo_q[46:0], div_ge};
          end
        end
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_WRITE && out_free) begin
        out_valid_q <= 1'b1;
        out_q       <= oor_q ? '0 : upd;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign sample_count_o     = out_q.count;
  assign running_mean_o     = out_q.mean;
  assign running_variance_o = out_q.variance;
  assign least_latency_o    = out_q.min;
  assign greatest_latency_o = out_q.max;

endmodule

FILE: hdl/brs_checker.sv
// Port-level checks for the bucketed running statistics core.
// Depends on brs_pkg; bound to bucketed_running_stats_core below.
module brs_checker
  import brs_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] sample_count_o,
  input logic [47:0] running_mean_o,
  input logic [63:0] running_variance_o,
  input logic [31:0] least_latency_o,
  input logic [31:0] greatest_latency_o
);

  // One item at a time: after an accept the input stalls.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("item accepted while busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(sample_count_o)))
    else $error("stalled item dropped or changed");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && sample_count_o == 32'd0) |->
      (running_mean_o == 48'd0 && running_variance_o == 64'd0 &&
       least_latency_o == 32'd0 && greatest_latency_o == 32'd0))
    else $error("out-of-range item not all zero");

  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && sample_count_o != 32'd0) |-> (least_latency_o <= greatest_latency_o))
    else $error("min above max");

  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && sample_count_o == 32'd1) |->
      (running_variance_o == 64'd0 && least_latency_o == greatest_latency_o &&
       running_mean_o == {least_latency_o, 16'h0000}))
    else $error("first sample statistics wrong");

endmodule

bind bucketed_running_stats_core brs_checker u_brs_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .sample_count_o    (sample_count_o),
  .running_mean_o    (running_mean_o),
  .running_variance_o(running_variance_o),
  .least_latency_o   (least_latency_o),
  .greatest_latency_o(greatest_latency_o)
);
